/* design/lcdt_pkg.sv */
// ----------------------------------------------------------------------------
// lcdt_pkg
// Shared types and constants for the LCD mode and line timing block.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdt_pkg;

   // line timing
   localparam int unsigned DOT_W        = 9;
   localparam int unsigned LINE_W       = 8;
   localparam logic [DOT_W-1:0]  LINE_DOTS   = 9'd456;
   localparam logic [DOT_W-1:0]  OAM_BOUND   = LINE_DOTS - 9'd80;
   localparam logic [DOT_W-1:0]  XFER_BOUND  = OAM_BOUND - 9'd172;
   localparam logic [LINE_W-1:0] VBLANK_LINE = 8'd144;
   localparam logic [LINE_W-1:0] LAST_LINE   = 8'd153;

   // register port
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_EN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HBLANK_EN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VBLANK_EN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OAM_EN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LYC_EN     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_CMP   = 3'd5;

   // lcd modes
   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } lcd_mode_type;

   typedef struct packed {
      logic              display_enable;
      logic              hblank_irq_enable;
      logic              vblank_irq_enable;
      logic              oam_irq_enable;
      logic              lyc_irq_enable;
      logic [LINE_W-1:0] line_compare;
   } cfg_type;

   typedef struct packed {
      logic [DOT_W-1:0]  dot_countdown;
      logic [LINE_W-1:0] line_count;
      lcd_mode_type      mode_bits;
      logic              match_flag;
   } timing_state_type;

   typedef struct packed {
      lcd_mode_type      lcd_mode;
      logic [LINE_W-1:0] current_line;
      logic              coincidence;
      logic              mode_irq;
      logic              match_irq;
      logic              vblank_irq;
      logic              draw_line;
   } result_type;

endpackage

`default_nettype wire

/* design/lcd_mode_and_line_timing.sv */
// ----------------------------------------------------------------------------
// lcd_mode_and_line_timing
// LCD mode, line counter and status interrupt timing, one CPU step per item.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | req_elapsed_cycles
//   rsp     | out       | rsp_valid/rsp_ready | rsp_lcd_mode .. rsp_draw_line
//   csr     | in        | csr_we              | csr_index, csr_wdata
//
// One item per cycle while the result register is empty or being taken; its
// result appears in the cycle after acceptance, from the result register fed by
// the single step of timing logic. Synchronous reset sets the countdown to 456,
// line, mode, flag and settings to zero; the result register starts empty.
// A stalled result holds; req_ready stays high while the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_mode_and_line_timing
   import lcdt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // step items
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_elapsed_cycles,
   // results
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_lcd_mode,
   output logic [7:0]                 rsp_current_line,
   output logic                       rsp_coincidence,
   output logic                       rsp_mode_irq,
   output logic                       rsp_match_irq,
   output logic                       rsp_vblank_irq,
   output logic                       rsp_draw_line,
   // registers
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   timing_state_type state_ff, state_in;
   timing_state_type step_nxt;
   result_type       step_res;
   result_type       rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             req_take;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DISPLAY_EN: cfg_in.display_enable    = csr_wdata[0];
            CSR_HBLANK_EN:  cfg_in.hblank_irq_enable = csr_wdata[0];
            CSR_VBLANK_EN:  cfg_in.vblank_irq_enable = csr_wdata[0];
            CSR_OAM_EN:     cfg_in.oam_irq_enable    = csr_wdata[0];
            CSR_LYC_EN:     cfg_in.lyc_irq_enable    = csr_wdata[0];
            CSR_LINE_CMP:   cfg_in.line_compare      = csr_wdata[LINE_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // timing step
   lcdt_step u_step (
      .cfg            (cfg_ff),
      .cur            (state_ff),
      .elapsed_cycles (req_elapsed_cycles),
      .nxt            (step_nxt),
      .res            (step_res)
   );

   // handshake
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_take     = req_valid && req_ready;
   assign state_in     = req_take ? step_nxt : state_ff;
   assign rsp_valid_in = req_take || (rsp_valid_ff && !rsp_ready);

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                 <= '0;
         state_ff.dot_countdown <= LINE_DOTS;
         state_ff.line_count    <= '0;
         state_ff.mode_bits     <= MODE_HBLANK;
         state_ff.match_flag    <= 1'b0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lcd_mode     = rsp_ff.lcd_mode;
   assign rsp_current_line = rsp_ff.current_line;
   assign rsp_coincidence  = rsp_ff.coincidence;
   assign rsp_mode_irq     = rsp_ff.mode_irq;
   assign rsp_match_irq    = rsp_ff.match_irq;
   assign rsp_vblank_irq   = rsp_ff.vblank_irq;
   assign rsp_draw_line    = rsp_ff.draw_line;

endmodule

`default_nettype wire

/* design/lcdt_step.sv */
// ----------------------------------------------------------------------------
// lcdt_step
// One CPU step of line timing: mode select, countdown update, line advance
// and compare, all combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdt_step
   import lcdt_pkg::*;
(
   input  wire cfg_type          cfg,
   input  wire timing_state_type cur,
   input  wire logic [7:0]       elapsed_cycles,
   output timing_state_type      nxt,
   output result_type            res
);

   lcd_mode_type      new_mode;
   logic              mode_en;
   logic              line_end;
   logic [LINE_W-1:0] line_inc;
   logic [LINE_W-1:0] line_next;

   // mode from line and countdown before the decrement
   always_comb begin
      if (cur.line_count >= VBLANK_LINE) begin
         new_mode = MODE_VBLANK;
         mode_en  = cfg.vblank_irq_enable;
      end else if (cur.dot_countdown >= OAM_BOUND) begin
         new_mode = MODE_OAM;
         mode_en  = cfg.oam_irq_enable;
      end else if (cur.dot_countdown >= XFER_BOUND) begin
         new_mode = MODE_XFER;
         mode_en  = 1'b0;
      end else begin
         new_mode = MODE_HBLANK;
         mode_en  = cfg.hblank_irq_enable;
      end
   end

   // line ends when the countdown would reach zero or below
   assign line_end  = (cur.dot_countdown <= {1'b0, elapsed_cycles});
   assign line_inc  = cur.line_count + 8'd1;
   assign line_next = (line_inc != VBLANK_LINE && line_inc > LAST_LINE) ? '0 : line_inc;

   // next state and result
   always_comb begin
      nxt = cur;
      res = '0;
      if (!cfg.display_enable) begin
         nxt.dot_countdown = LINE_DOTS;
         nxt.mode_bits     = MODE_HBLANK;
         nxt.line_count    = '0;
      end else begin
         nxt.mode_bits = new_mode;
         res.mode_irq  = mode_en && (cur.mode_bits != new_mode);
         if (line_end) begin
            nxt.dot_countdown = LINE_DOTS;
            nxt.line_count    = line_next;
            nxt.match_flag    = (line_next == cfg.line_compare);
            res.match_irq     = (line_next == cfg.line_compare) && cfg.lyc_irq_enable;
            res.vblank_irq    = (line_inc == VBLANK_LINE);
            res.draw_line     = (line_next < VBLANK_LINE);
         end else begin
            nxt.dot_countdown = cur.dot_countdown - {1'b0, elapsed_cycles};
         end
      end
      res.lcd_mode     = nxt.mode_bits;
      res.current_line = nxt.line_count;
      res.coincidence  = nxt.match_flag;
   end

endmodule

`default_nettype wire

/* tb/lcdt_status_checker.sv */
// ----------------------------------------------------------------------------
// lcdt_status_checker
// Watches the step, result and register ports of the LCD timing block, keeps
// its own copy of the registers and the line timing state, works out the
// status each accepted step should produce and compares it with what comes
// out of the result channel, field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdt_status_checker
   import lcdt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [7:0]            req_elapsed_cycles,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [1:0]            rsp_lcd_mode,
   input  wire logic [7:0]            rsp_current_line,
   input  wire logic                  rsp_coincidence,
   input  wire logic                  rsp_mode_irq,
   input  wire logic                  rsp_match_irq,
   input  wire logic                  rsp_vblank_irq,
   input  wire logic                  rsp_draw_line,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         error_count,
   output int                         steps_in_flight
);

   cfg_type          regs;
   timing_state_type timing;
   result_type       expected_status[$];
   result_type       want;
   int               result_index = 0;

   task automatic log_mismatch(input string what);
      error_count++;
      if (error_count <= 50)
         $display("%0t: status %0d: %s", $time, result_index, what);
   endtask

   task automatic check_field(input string name, input int got, input int exp_val);
      if (got != exp_val)
         log_mismatch($sformatf("%s got %0d, expected %0d", name, got, exp_val));
   endtask

   // one cpu step of the line timing, updates the local state
   task automatic step_lcd_timing(input logic [7:0] cycles, output result_type r);
      lcd_mode_type next_mode;
      logic         irq_en;
      int           remain;
      r = '0;
      if (!regs.display_enable) begin
         // display off forces idle timing, coincidence flag is kept
         timing.dot_countdown = LINE_DOTS;
         timing.line_count    = '0;
         timing.mode_bits     = MODE_HBLANK;
      end else begin
         // mode from the line and the countdown before this step
         if (timing.line_count >= VBLANK_LINE) begin
            next_mode = MODE_VBLANK;
            irq_en    = regs.vblank_irq_enable;
         end else if (timing.dot_countdown >= OAM_BOUND) begin
            next_mode = MODE_OAM;
            irq_en    = regs.oam_irq_enable;
         end else if (timing.dot_countdown >= XFER_BOUND) begin
            next_mode = MODE_XFER;
            irq_en    = 1'b0;
         end else begin
            next_mode = MODE_HBLANK;
            irq_en    = regs.hblank_irq_enable;
         end
         r.mode_irq       = irq_en && (next_mode != timing.mode_bits);
         timing.mode_bits = next_mode;

         // countdown, reload without carry and line advance
         remain = int'(timing.dot_countdown) - int'(cycles);
         if (remain <= 0) begin
            remain = int'(LINE_DOTS);
            timing.line_count = timing.line_count + 8'd1;
            if (timing.line_count == VBLANK_LINE)
               r.vblank_irq = 1'b1;
            else if (timing.line_count > LAST_LINE)
               timing.line_count = '0;
            timing.match_flag = (timing.line_count == regs.line_compare);
            r.match_irq       = timing.match_flag && regs.lyc_irq_enable;
            r.draw_line       = (timing.line_count < VBLANK_LINE);
         end
         timing.dot_countdown = remain[8:0];
      end
      r.lcd_mode     = timing.mode_bits;
      r.current_line = timing.line_count;
      r.coincidence  = timing.match_flag;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         regs                 = '0;
         timing.dot_countdown = LINE_DOTS;
         timing.line_count    = '0;
         timing.mode_bits     = MODE_HBLANK;
         timing.match_flag    = 1'b0;
         expected_status.delete();
      end else begin
         // result item against the oldest expected status
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               log_mismatch("result item with no step pending");
            end else begin
               want = expected_status.pop_front();
               check_field("lcd_mode", rsp_lcd_mode, want.lcd_mode);
               check_field("current_line", rsp_current_line, want.current_line);
               check_field("coincidence", rsp_coincidence, want.coincidence);
               check_field("mode_irq", rsp_mode_irq, want.mode_irq);
               check_field("match_irq", rsp_match_irq, want.match_irq);
               check_field("vblank_irq", rsp_vblank_irq, want.vblank_irq);
               check_field("draw_line", rsp_draw_line, want.draw_line);
            end
            result_index++;
         end

         // accepted step item
         if (req_valid && req_ready) begin
            step_lcd_timing(req_elapsed_cycles, want);
            expected_status.push_back(want);
         end

         // register writes, unused indexes are ignored
         if (csr_we) begin
            case (csr_index)
               CSR_DISPLAY_EN: regs.display_enable    = csr_wdata[0];
               CSR_HBLANK_EN:  regs.hblank_irq_enable = csr_wdata[0];
               CSR_VBLANK_EN:  regs.vblank_irq_enable = csr_wdata[0];
               CSR_OAM_EN:     regs.oam_irq_enable    = csr_wdata[0];
               CSR_LYC_EN:     regs.lyc_irq_enable    = csr_wdata[0];
               CSR_LINE_CMP:   regs.line_compare      = csr_wdata;
               default: ;
            endcase
         end
      end
      steps_in_flight = expected_status.size();
   end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives CPU step items into the LCD mode and line timing block with random
// gaps and result stalls, walks through a directed sequence over the mode
// boundaries and display disable, then runs random phases under several
// register settings. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import lcdt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 8;
   localparam int PHASE_STEPS = 210;
   localparam int DARK_STEPS  = 30;
   localparam int HOLD_CYCLES = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_elapsed_cycles = '0;
   logic                  rsp_valid;
   logic                  rsp_ready          = 1'b0;
   logic [1:0]            rsp_lcd_mode;
   logic [7:0]            rsp_current_line;
   logic                  rsp_coincidence;
   logic                  rsp_mode_irq;
   logic                  rsp_match_irq;
   logic                  rsp_vblank_irq;
   logic                  rsp_draw_line;
   logic                  csr_we             = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index          = '0;
   logic [CSR_DATA_W-1:0] csr_wdata          = '0;

   int error_count;
   int steps_in_flight;
   int cycle_count   = 0;
   int send_run_left = 0;
   bit send_quiet    = 1'b0;
   int take_run_left = 0;
   bit take_quiet    = 1'b0;
   bit hold_off      = 1'b0;
   int rsp_taken     = 0;

   lcd_mode_and_line_timing DUT (.*);
   lcdt_status_checker checker_i (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // wait per item, with stretches of no waiting at all
   function automatic int draw_wait(inout int run_left, inout bit quiet);
      if (run_left == 0) begin
         run_left = $urandom_range(16, 64);
         quiet    = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      return quiet ? 0 : $urandom_range(0, 11);
   endfunction

   // mostly long steps so the frame gets through vblank and wraps
   function automatic logic [7:0] pick_elapsed();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 8'($urandom_range(190, 255));
      if (roll < 88) return 8'($urandom_range(0, 255));
      if (roll < 96) return 8'($urandom_range(0, 6));
      return roll[0] ? 8'd255 : 8'd0;
   endfunction

   // one step item, called and returning at a falling edge
   task automatic send_step(input logic [7:0] cycles);
      int gap;
      gap = hold_off ? 0 : draw_wait(send_run_left, send_quiet);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_elapsed_cycles <= cycles;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
   endtask

   // stop sending and wait for every result to come back
   task automatic settle();
      req_valid <= 1'b0;
      while (steps_in_flight != 0) @(negedge clock);
   endtask

   // leaves the write enable high, the caller drops it
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // all registers, junk in the unused upper bits of the enables
   task automatic write_settings(input cfg_type s);
      settle();
      write_reg(CSR_DISPLAY_EN, {7'($urandom), s.display_enable});
      write_reg(CSR_HBLANK_EN, {7'($urandom), s.hblank_irq_enable});
      write_reg(CSR_VBLANK_EN, {7'($urandom), s.vblank_irq_enable});
      write_reg(CSR_OAM_EN, {7'($urandom), s.oam_irq_enable});
      write_reg(CSR_LYC_EN, {7'($urandom), s.lyc_irq_enable});
      write_reg(CSR_LINE_CMP, s.line_compare);
      csr_we <= 1'b0;
   endtask

   // result side, with two long hold-offs that back up the step channel
   initial begin
      int hold;
      wait (reset == 1'b0);
      forever begin
         if (rsp_taken == 300 || rsp_taken == 1100) begin
            hold     = HOLD_CYCLES;
            hold_off = 1'b1;
         end else begin
            hold = draw_wait(take_run_left, take_quiet);
         end
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         hold_off = 1'b0;
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         rsp_taken++;
         @(negedge clock);
      end
   end

   // stimulus
   initial begin
      cfg_type s;
      int      n;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // display off after reset: idle timing
      send_step(8'd0);
      send_step(8'd255);
      send_step(8'd7);

      // writes to unused indexes change nothing
      settle();
      write_reg(CSR_SPARE_A, 8'hFF);
      write_reg(CSR_SPARE_B, 8'hFF);
      csr_we <= 1'b0;
      send_step(8'd1);

      // walk across the oam, transfer and hblank bounds, then line advances
      s = '0;
      s.display_enable    = 1'b1;
      s.hblank_irq_enable = 1'b1;
      s.vblank_irq_enable = 1'b1;
      s.oam_irq_enable    = 1'b1;
      s.lyc_irq_enable    = 1'b1;
      s.line_compare      = 8'd2;
      write_settings(s);
      send_step(8'd0);
      send_step(8'd80);
      send_step(8'd0);
      send_step(8'd172);
      send_step(8'd0);
      send_step(8'd1);
      send_step(8'd0);
      send_step(8'd203);
      send_step(8'd255);
      send_step(8'd255);

      // display off mid frame keeps the coincidence flag
      settle();
      write_reg(CSR_DISPLAY_EN, 8'hFE);
      csr_we <= 1'b0;
      send_step(8'd9);

      // back on with the oam and hblank enables cleared
      s.hblank_irq_enable = 1'b0;
      s.oam_irq_enable    = 1'b0;
      write_settings(s);
      send_step(8'd255);
      send_step(8'd255);

      // random phases under different settings
      for (int p = 0; p < PHASES; p++) begin
         s.display_enable    = (p != 3);
         s.hblank_irq_enable = 1'($urandom_range(0, 1));
         s.vblank_irq_enable = 1'($urandom_range(0, 1));
         s.oam_irq_enable    = 1'($urandom_range(0, 1));
         s.lyc_irq_enable    = 1'($urandom_range(0, 1));
         s.line_compare      = 8'($urandom_range(0, 153));
         case (p)
            0: begin
               s.hblank_irq_enable = 1'b1;
               s.vblank_irq_enable = 1'b1;
               s.oam_irq_enable    = 1'b1;
               s.lyc_irq_enable    = 1'b1;
               s.line_compare      = 8'd0;
            end
            1: begin
               s.hblank_irq_enable = 1'b0;
               s.vblank_irq_enable = 1'b0;
               s.oam_irq_enable    = 1'b0;
               s.lyc_irq_enable    = 1'b0;
               s.line_compare      = 8'd255;
            end
            2: s.line_compare = LAST_LINE;
            3: s.line_compare = VBLANK_LINE;
            default: ;
         endcase
         write_settings(s);
         n = (p == 3) ? DARK_STEPS : PHASE_STEPS;
         repeat (n) send_step(pick_elapsed());
      end

      // drain and verdict
      settle();
      repeat (4) @(negedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
